>>> hw/rtl/tqts_pkg.sv
// ----------------------------------------------------------------------------
// Three-queue thread scheduler package
// Shared widths, operation, source and status codes, and the small structs
// that pass between the scheduler, its queue chains and the queue cells.
// ----------------------------------------------------------------------------
package tqts_pkg;

  // Fixed widths of the word fields.
  localparam int THREAD_W  = 5;
  localparam int TICK_IN_W = 32;
  localparam int OP_W      = 2;
  localparam int FROM_W    = 2;
  localparam int STATUS_W  = 2;

  // Defaults for the top-level parameters.
  localparam int MAX_THREADS_DEF = 32;
  localparam int TICK_BITS_DEF   = 32;

  // Operation codes carried by an input word.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_NEW   = 2'd0,
    OP_PUSH_WAIT  = 2'd1,
    OP_PUSH_SLEEP = 2'd2,
    OP_SCHEDULE   = 2'd3
  } op_t;

  // Queue that served a schedule request.
  typedef enum logic [FROM_W-1:0] {
    SRC_NEW   = 2'd0,
    SRC_SLEEP = 2'd1,
    SRC_WAIT  = 2'd2
  } src_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NONE_READY = 2'd1,
    STAT_REJECTED   = 2'd2
  } status_t;

  // One queue entry tag: occupied flag and thread slot.
  typedef struct packed {
    logic                vld;
    logic [THREAD_W-1:0] id;
  } tag_t;

  // Command from the scheduler to one queue chain.
  typedef struct packed {
    logic                push;
    logic                pop;
    logic [THREAD_W-1:0] id;
  } chain_cmd_t;

endpackage

>>> hw/rtl/three_queue_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// Three-queue thread scheduler core
// Schedules thread slots from a new queue, a sleep list sorted by wake tick
// and a waiting queue, each held in a row of queue cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes one word per operation:
//   push new, push waiting, push sleeping or schedule. Every word gives
//   exactly one result word on the output channel (out_valid / out_stall).
//   A result is registered, in the output register or, while that holds a
//   waiting result, in the skid register. A schedule word starts no walk.
//   A push walks its entry down the target queue's cell row one cell per
//   cycle; the walk length is set by the number of entries in that queue.
//   No further word is taken during the walk. A two-word output buffer lets
//   one more word be taken while a result waits; when both are full
//   in_stall stays high. Reset empties all three queues and marks every
//   slot as not queued; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module three_queue_thread_scheduler_core
  import tqts_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF,
  parameter int TICK_BITS   = TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [THREAD_W-1:0]  in_thread_id,
  input  logic [TICK_IN_W-1:0] in_wake_tick,
  input  logic [TICK_IN_W-1:0] in_current_tick,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_granted,
  output logic [THREAD_W-1:0]  out_granted_thread,
  output logic [FROM_W-1:0]    out_granted_from,
  output logic [STATUS_W-1:0]  out_status
);

  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);

  typedef struct packed {
    logic                granted;
    logic [THREAD_W-1:0] thread;
    src_t                from;
    status_t             status;
  } result_t;

  // Control and queue bookkeeping registers.
  logic                   busy_r,     busy_nxt;
  logic [CNT_W-1:0]       walk_r,     walk_nxt;
  logic [CNT_W-1:0]       cnt_new_r,  cnt_new_nxt;
  logic [CNT_W-1:0]       cnt_wait_r, cnt_wait_nxt;
  logic [CNT_W-1:0]       cnt_slp_r,  cnt_slp_nxt;
  logic [MAX_THREADS-1:0] queued_r,   queued_nxt;
  logic                   out_vld_r,  out_vld_nxt;
  logic                   skid_vld_r, skid_vld_nxt;
  result_t                out_res_r,  out_res_nxt;
  result_t                skid_res_r, skid_res_nxt;

  logic                   acc;
  op_t                    op;
  logic                   slot_ok;
  logic [SLOT_W-1:0]      slot_idx;
  logic                   reject;
  logic [TICK_BITS-1:0]   wake;
  logic [TICK_BITS-1:0]   now;
  logic                   sleep_ready;
  logic                   sel_new, sel_slp, sel_wait;
  logic [THREAD_W-1:0]    pop_id;
  logic [CNT_W-1:0]       target_cnt;
  result_t                res;
  chain_cmd_t             cmd_new, cmd_wait, cmd_slp;
  tag_t                   front_new, front_wait, front_slp;
  logic [TICK_BITS-1:0]   tick_new, tick_wait, tick_slp;
  logic                   out_take;

  // Input handshake: held off during a push walk or with both result slots full.
  assign in_stall = busy_r | skid_vld_r;
  assign acc      = in_valid & ~in_stall;
  assign op       = op_t'(in_operation);

  // Slot checks and tick truncation to the configured width.
  assign slot_ok  = 32'(in_thread_id) < 32'(MAX_THREADS);
  assign slot_idx = SLOT_W'(in_thread_id);
  assign reject   = ~slot_ok | queued_r[slot_idx];
  assign wake     = TICK_BITS'(in_wake_tick);
  assign now      = TICK_BITS'(in_current_tick);

  // Schedule priority: new head, then a due sleep head, then waiting head.
  assign sleep_ready = front_slp.vld & (tick_slp <= now);
  assign sel_new     = front_new.vld;
  assign sel_slp     = ~sel_new & sleep_ready;
  assign sel_wait    = ~sel_new & ~sleep_ready & front_wait.vld;

  // Decode the word into chain commands and a result.
  always_comb begin
    cmd_new    = '{push: 1'b0, pop: 1'b0, id: in_thread_id};
    cmd_wait   = '{push: 1'b0, pop: 1'b0, id: in_thread_id};
    cmd_slp    = '{push: 1'b0, pop: 1'b0, id: in_thread_id};
    res        = '{granted: 1'b0, thread: '0, from: SRC_NEW, status: STAT_OK};
    pop_id     = '0;
    target_cnt = '0;
    unique case (op)
      OP_PUSH_NEW: begin
        cmd_new.push = acc & ~reject;
        target_cnt   = cnt_new_r;
      end
      OP_PUSH_WAIT: begin
        cmd_wait.push = acc & ~reject;
        target_cnt    = cnt_wait_r;
      end
      OP_PUSH_SLEEP: begin
        cmd_slp.push = acc & ~reject;
        target_cnt   = cnt_slp_r;
      end
      OP_SCHEDULE: begin
        cmd_new.pop  = acc & sel_new;
        cmd_slp.pop  = acc & sel_slp;
        cmd_wait.pop = acc & sel_wait;
        if (sel_new) begin
          pop_id = front_new.id;
          res    = '{granted: 1'b1, thread: front_new.id, from: SRC_NEW, status: STAT_OK};
        end else if (sel_slp) begin
          pop_id = front_slp.id;
          res    = '{granted: 1'b1, thread: front_slp.id, from: SRC_SLEEP, status: STAT_OK};
        end else if (sel_wait) begin
          pop_id = front_wait.id;
          res    = '{granted: 1'b1, thread: front_wait.id, from: SRC_WAIT, status: STAT_OK};
        end else begin
          res.status = STAT_NONE_READY;
        end
      end
      default: begin
        res.status = STAT_NONE_READY;
      end
    endcase
    if (op != OP_SCHEDULE && reject) begin
      res.status = STAT_REJECTED;
    end
  end

  // Queue counts, queued marks and the push walk timer.
  always_comb begin
    cnt_new_nxt  = cnt_new_r;
    cnt_wait_nxt = cnt_wait_r;
    cnt_slp_nxt  = cnt_slp_r;
    queued_nxt   = queued_r;
    busy_nxt     = busy_r;
    walk_nxt     = walk_r;
    if (busy_r) begin
      if (walk_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        walk_nxt = walk_r - CNT_W'(1);
      end
    end
    if (cmd_new.push | cmd_wait.push | cmd_slp.push) begin
      queued_nxt[slot_idx] = 1'b1;
      if (target_cnt != '0) begin
        busy_nxt = 1'b1;
        walk_nxt = target_cnt - CNT_W'(1);
      end
    end
    if (cmd_new.pop | cmd_wait.pop | cmd_slp.pop) begin
      queued_nxt[SLOT_W'(pop_id)] = 1'b0;
    end
    if (cmd_new.push)  cnt_new_nxt  = cnt_new_r  + CNT_W'(1);
    if (cmd_wait.push) cnt_wait_nxt = cnt_wait_r + CNT_W'(1);
    if (cmd_slp.push)  cnt_slp_nxt  = cnt_slp_r  + CNT_W'(1);
    if (cmd_new.pop)   cnt_new_nxt  = cnt_new_r  - CNT_W'(1);
    if (cmd_wait.pop)  cnt_wait_nxt = cnt_wait_r - CNT_W'(1);
    if (cmd_slp.pop)   cnt_slp_nxt  = cnt_slp_r  - CNT_W'(1);
  end

  // Two-word result buffer: output register plus skid register.
  assign out_take = out_vld_r & ~out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (skid_vld_r) begin
      if (out_take) begin
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (acc) begin
      if (!out_vld_r || out_take) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = res;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_res_nxt = res;
      end
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      walk_r     <= '0;
      cnt_new_r  <= '0;
      cnt_wait_r <= '0;
      cnt_slp_r  <= '0;
      queued_r   <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      walk_r     <= walk_nxt;
      cnt_new_r  <= cnt_new_nxt;
      cnt_wait_r <= cnt_wait_nxt;
      cnt_slp_r  <= cnt_slp_nxt;
      queued_r   <= queued_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  // The FIFO queues carry a constant tick, so their cells never reorder.
  tqts_chain #(
    .Depth(MAX_THREADS),
    .TickW(TICK_BITS)
  ) u_chain_new (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_new),
    .cmd_tick  ('0),
    .front     (front_new),
    .front_tick(tick_new)
  );

  tqts_chain #(
    .Depth(MAX_THREADS),
    .TickW(TICK_BITS)
  ) u_chain_wait (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_wait),
    .cmd_tick  ('0),
    .front     (front_wait),
    .front_tick(tick_wait)
  );

  // The sleep list is ordered by wake tick.
  tqts_chain #(
    .Depth(MAX_THREADS),
    .TickW(TICK_BITS)
  ) u_chain_sleep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_slp),
    .cmd_tick  (wake),
    .front     (front_slp),
    .front_tick(tick_slp)
  );

  // Output ports.
  assign out_valid          = out_vld_r;
  assign out_granted        = out_res_r.granted;
  assign out_granted_thread = out_res_r.thread;
  assign out_granted_from   = out_res_r.from;
  assign out_status         = out_res_r.status;

endmodule

>>> hw/rtl/tqts_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queue entry. An entry travelling down the chain either settles
// in an empty cell, displaces a later-ordered entry, or moves on. An entry
// that has been displaced moves the rest of the row along by one cell. A pop
// shifts every cell one place towards the head.
// ----------------------------------------------------------------------------
module tqts_cell
  import tqts_pkg::*;
#(
  parameter int TickW = TICK_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop,
  input  tag_t             carry_in_tag,
  input  logic [TickW-1:0] carry_in_tick,
  input  logic             carry_in_shift,
  input  tag_t             next_tag,
  input  logic [TickW-1:0] next_tick,
  output tag_t             carry_out_tag,
  output logic [TickW-1:0] carry_out_tick,
  output logic             carry_out_shift,
  output tag_t             held_tag,
  output logic [TickW-1:0] held_tick
);

  tag_t             held_tag_r,    held_tag_nxt;
  logic [TickW-1:0] held_tick_r,   held_tick_nxt;
  tag_t             carry_tag_r,   carry_tag_nxt;
  logic [TickW-1:0] carry_tick_r,  carry_tick_nxt;
  logic             carry_shift_r, carry_shift_nxt;

  // Settle, swap or pass the travelling entry; a strictly earlier tick
  // goes in front, so equal ticks keep their arrival order. An entry that
  // was pushed out of its cell always takes the next place, so the entries
  // behind it keep their order too.
  always_comb begin
    held_tag_nxt    = held_tag_r;
    held_tick_nxt   = held_tick_r;
    carry_tag_nxt   = '0;
    carry_tick_nxt  = carry_in_tick;
    carry_shift_nxt = 1'b0;
    if (pop) begin
      held_tag_nxt  = next_tag;
      held_tick_nxt = next_tick;
    end else if (carry_in_tag.vld) begin
      if (!held_tag_r.vld) begin
        held_tag_nxt  = carry_in_tag;
        held_tick_nxt = carry_in_tick;
      end else if (carry_in_shift || (carry_in_tick < held_tick_r)) begin
        held_tag_nxt    = carry_in_tag;
        held_tick_nxt   = carry_in_tick;
        carry_tag_nxt   = held_tag_r;
        carry_tick_nxt  = held_tick_r;
        carry_shift_nxt = 1'b1;
      end else begin
        carry_tag_nxt = carry_in_tag;
      end
    end
  end

  // Cell registers; only the tags and the shift flag need a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_tag_r    <= '0;
      carry_tag_r   <= '0;
      carry_shift_r <= 1'b0;
    end else begin
      held_tag_r    <= held_tag_nxt;
      carry_tag_r   <= carry_tag_nxt;
      carry_shift_r <= carry_shift_nxt;
    end
    held_tick_r  <= held_tick_nxt;
    carry_tick_r <= carry_tick_nxt;
  end

  assign held_tag        = held_tag_r;
  assign held_tick       = held_tick_r;
  assign carry_out_tag   = carry_tag_r;
  assign carry_out_tick  = carry_tick_r;
  assign carry_out_shift = carry_shift_r;

endmodule

>>> hw/rtl/tqts_chain.sv
// ----------------------------------------------------------------------------
// Queue chain
// A row of queue cells forming one ordered queue. Pushes enter at the head
// cell and travel one cell per cycle; a pop shifts the whole row forward.
// A chain fed with constant ticks behaves as a plain FIFO.
// ----------------------------------------------------------------------------
module tqts_chain
  import tqts_pkg::*;
#(
  parameter int Depth = MAX_THREADS_DEF,
  parameter int TickW = TICK_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  chain_cmd_t       cmd,
  input  logic [TickW-1:0] cmd_tick,
  output tag_t             front,
  output logic [TickW-1:0] front_tick
);

  tag_t             carry_tag   [0:Depth];
  logic [TickW-1:0] carry_tick  [0:Depth];
  logic             carry_shift [0:Depth];
  tag_t             held_tag    [0:Depth];
  logic [TickW-1:0] held_tick   [0:Depth];

  // A push is presented to the head cell in the cycle it is accepted.
  assign carry_tag[0]   = '{vld: cmd.push, id: cmd.id};
  assign carry_tick[0]  = cmd_tick;
  assign carry_shift[0] = 1'b0;

  // Beyond the last cell the queue is always empty.
  assign held_tag[Depth]  = '0;
  assign held_tick[Depth] = '0;

  // The row of cells.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    tqts_cell #(
      .TickW(TickW)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .pop            (cmd.pop),
      .carry_in_tag   (carry_tag[i]),
      .carry_in_tick  (carry_tick[i]),
      .carry_in_shift (carry_shift[i]),
      .next_tag       (held_tag[i+1]),
      .next_tick      (held_tick[i+1]),
      .carry_out_tag  (carry_tag[i+1]),
      .carry_out_tick (carry_tick[i+1]),
      .carry_out_shift(carry_shift[i+1]),
      .held_tag       (held_tag[i]),
      .held_tick      (held_tick[i])
    );
  end

  assign front      = held_tag[0];
  assign front_tick = held_tick[0];

endmodule

>>> hw/rtl/tqts_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the result channel of the scheduler core and checks that result
// words are consistent and well behaved over time.
// ----------------------------------------------------------------------------
module tqts_checker
  import tqts_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_granted,
  input logic [THREAD_W-1:0] out_granted_thread,
  input logic [FROM_W-1:0]   out_granted_from,
  input logic [STATUS_W-1:0] out_status
);

  // No result word may be offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word offered after reset");

  // A stalled result word stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted)
      && $stable(out_granted_thread) && $stable(out_granted_from)
      && $stable(out_status))
    else $error("stalled result word changed");

  // A granted thread always comes with an ok status and a real source queue.
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_status == STAT_OK
      && (out_granted_from == SRC_NEW || out_granted_from == SRC_SLEEP
          || out_granted_from == SRC_WAIT))
    else $error("grant with bad status or source");

  // A word without a grant carries a zero thread and source.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_granted_thread == '0
      && out_granted_from == SRC_NEW && out_status != STAT_OK
      || out_valid && !out_granted && out_status == STAT_OK
      && out_granted_thread == '0 && out_granted_from == SRC_NEW)
    else $error("result without grant has stray fields");

endmodule

bind three_queue_thread_scheduler_core tqts_checker u_tqts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_granted       (out_granted),
  .out_granted_thread(out_granted_thread),
  .out_granted_from  (out_granted_from),
  .out_status        (out_status)
);
